[design/bilinear_table_lookup_2d_unit_defines.svh]
// assertion macros for the bilinear table lookup unit
`ifndef BILINEAR_TABLE_LOOKUP_2D_UNIT_DEFINES_SVH
`define BILINEAR_TABLE_LOOKUP_2D_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define BTL2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define BTL2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/btl2d_pkg.sv]
// shared types and constants of the bilinear table lookup unit
package btl2d_pkg;

  localparam int DEF_MAX_X_POINTS = 16;
  localparam int DEF_MAX_Y_POINTS = 16;
  localparam int FRAC_BITS        = 24;
  localparam int COUNT_W          = 5;

  // -999.999 in Q16.16
  localparam logic signed [31:0] BAD_RESULT = -32'sd65535934;

  localparam logic [1:0] ACT_WR_X    = 2'd0;
  localparam logic [1:0] ACT_WR_Y    = 2'd1;
  localparam logic [1:0] ACT_WR_GRID = 2'd2;
  localparam logic [1:0] ACT_EVAL    = 2'd3;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SRCH_X,
    PH_SRCH_Y,
    PH_DIV_X,
    PH_DIV_Y,
    PH_GRID,
    PH_BLEND,
    PH_DONE
  } phase_t;

  typedef struct packed {
    phase_t phase;
    logic   start;
    logic   take_query;
    logic   take_write;
    logic   load_out;
  } cmd_t;

  typedef struct packed {
    logic done;
    logic empty;
  } sts_t;

endpackage

[design/btl2d_if.sv]
// transfer channels of the bilinear table lookup unit
interface btl2d_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [3:0]         index_x;
  logic [3:0]         index_y;
  logic signed [31:0] write_value;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;

  modport source (output valid, action, index_x, index_y, write_value, query_x, query_y,
                  input ready);
  modport sink (input valid, action, index_x, index_y, write_value, query_x, query_y,
                output ready);
endinterface

interface btl2d_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result;
  logic               status;

  modport source (output valid, result, status, input ready);
  modport sink (input valid, result, status, output ready);
endinterface

[design/btl2d_ctrl.sv]
// sequencing state machine of the bilinear table lookup unit
module btl2d_ctrl import btl2d_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_action,
  output logic       out_valid,
  input  logic       out_ready,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE, S_SRCH_X, S_SRCH_Y, S_DIV_X, S_DIV_Y, S_GRID, S_BLEND, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   start_r, start_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer, out_free, is_eval;

  assign in_ready  = (state_r == S_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign is_eval   = (in_action == ACT_EVAL);
  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = 1'b0;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && is_eval) begin
          if (sts.empty) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SRCH_X;
            start_nxt = 1'b1;
          end
        end
      end
      S_SRCH_X: if (sts.done) begin
        state_nxt = S_SRCH_Y;
        start_nxt = 1'b1;
      end
      S_SRCH_Y: if (sts.done) begin
        state_nxt = S_DIV_X;
        start_nxt = 1'b1;
      end
      S_DIV_X: if (sts.done) begin
        state_nxt = S_DIV_Y;
        start_nxt = 1'b1;
      end
      S_DIV_Y: if (sts.done) begin
        state_nxt = S_GRID;
        start_nxt = 1'b1;
      end
      S_GRID: if (sts.done) begin
        state_nxt = S_BLEND;
        start_nxt = 1'b1;
      end
      S_BLEND: if (sts.done) begin
        state_nxt = S_DONE;
      end
      S_DONE: if (out_free) begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      start_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      start_r     <= start_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    case (state_r)
      S_IDLE:   cmd.phase = PH_IDLE;
      S_SRCH_X: cmd.phase = PH_SRCH_X;
      S_SRCH_Y: cmd.phase = PH_SRCH_Y;
      S_DIV_X:  cmd.phase = PH_DIV_X;
      S_DIV_Y:  cmd.phase = PH_DIV_Y;
      S_GRID:   cmd.phase = PH_GRID;
      S_BLEND:  cmd.phase = PH_BLEND;
      S_DONE:   cmd.phase = PH_DONE;
      default:  cmd.phase = PH_IDLE;
    endcase
    cmd.start      = start_r;
    cmd.take_query = in_xfer && is_eval;
    cmd.take_write = in_xfer && !is_eval;
    cmd.load_out   = (state_r == S_DONE) && out_free;
  end

endmodule

[design/btl2d_dp.sv]
// table storage, search, divider and blend datapath of the lookup unit
module btl2d_dp import btl2d_pkg::*; #(
  parameter int MAX_X_POINTS = DEF_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = DEF_MAX_Y_POINTS
) (
  input  logic                clk,
  input  cmd_t                cmd,
  output sts_t                sts,
  input  logic [1:0]          action,
  input  logic [3:0]          index_x,
  input  logic [3:0]          index_y,
  input  logic signed [31:0]  write_value,
  input  logic signed [31:0]  query_x,
  input  logic signed [31:0]  query_y,
  input  logic [COUNT_W-1:0]  x_count,
  input  logic [COUNT_W-1:0]  y_count,
  output logic signed [31:0]  out_result,
  output logic                out_status
);

  localparam int XAW    = $clog2(MAX_X_POINTS);
  localparam int YAW    = $clog2(MAX_Y_POINTS);
  localparam int SAW    = (XAW > YAW) ? XAW : YAW;
  localparam int GDEPTH = MAX_X_POINTS * MAX_Y_POINTS;
  localparam int GAW    = $clog2(GDEPTH);
  localparam int DW     = 34;
  localparam int RW     = DW + 1;
  localparam int CW     = $clog2(FRAC_BITS);
  localparam int BW     = 36;
  localparam int PW     = BW + FRAC_BITS + 2;
  localparam logic signed [PW-1:0] RND = PW'(1) << (FRAC_BITS - 1);

  // counts in use
  logic [COUNT_W-1:0] nx, ny;
  assign nx = (32'(x_count) > MAX_X_POINTS) ? COUNT_W'(MAX_X_POINTS) : x_count;
  assign ny = (32'(y_count) > MAX_Y_POINTS) ? COUNT_W'(MAX_Y_POINTS) : y_count;
  assign sts.empty = (nx == '0) || (ny == '0);

  logic signed [31:0] qx_r, qy_r;
  always_ff @(posedge clk) begin
    if (cmd.take_query) begin
      qx_r <= query_x;
      qy_r <= query_y;
    end
  end

  // storage
  logic signed [31:0] xbp_mem [MAX_X_POINTS];
  logic signed [31:0] ybp_mem [MAX_Y_POINTS];
  logic signed [31:0] grid_mem [GDEPTH];
  logic signed [31:0] xbp_q_r, ybp_q_r, grid_q_r;
  logic               wr_x, wr_y, wr_g;
  logic [GAW-1:0]     g_wr_addr, g_rd_addr;
  logic [XAW-1:0]     x_rd_addr;
  logic [YAW-1:0]     y_rd_addr;

  assign wr_x = cmd.take_write && (action == ACT_WR_X) && (32'(index_x) < MAX_X_POINTS);
  assign wr_y = cmd.take_write && (action == ACT_WR_Y) && (32'(index_y) < MAX_Y_POINTS);
  assign wr_g = cmd.take_write && (action == ACT_WR_GRID) &&
                (32'(index_x) < MAX_X_POINTS) && (32'(index_y) < MAX_Y_POINTS);
  assign g_wr_addr = GAW'(index_x) * GAW'(MAX_Y_POINTS) + GAW'(index_y);

  always_ff @(posedge clk) begin
    if (wr_x) xbp_mem[XAW'(index_x)] <= write_value;
    xbp_q_r <= xbp_mem[x_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_y) ybp_mem[YAW'(index_y)] <= write_value;
    ybp_q_r <= ybp_mem[y_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_g) grid_mem[g_wr_addr] <= write_value;
    grid_q_r <= grid_mem[g_rd_addr];
  end

  // breakpoint search, one entry a cycle
  logic               srch, srch_x, s_eval, s_hit, s_last, s_done;
  logic [SAW-1:0]     j_r, jd_r, rd_idx, lo_idx;
  logic signed [31:0] prev_r, s_bp, s_q, lo_val;
  logic [COUNT_W-1:0] s_n;
  logic [XAW-1:0]     ix0_r, ix1_r;
  logic [YAW-1:0]     iy0_r, iy1_r;
  logic signed [31:0] xlo_r, xhi_r, ylo_r, yhi_r;

  assign srch_x    = (cmd.phase == PH_SRCH_X);
  assign srch      = srch_x || (cmd.phase == PH_SRCH_Y);
  assign rd_idx    = cmd.start ? '0 : j_r;
  assign x_rd_addr = XAW'(rd_idx);
  assign y_rd_addr = YAW'(rd_idx);
  assign s_bp      = srch_x ? xbp_q_r : ybp_q_r;
  assign s_q       = srch_x ? qx_r : qy_r;
  assign s_n       = srch_x ? nx : ny;
  assign s_eval    = srch && !cmd.start;
  assign s_hit     = s_q < s_bp;
  assign s_last    = (32'(jd_r) == (32'(s_n) - 1));
  assign s_done    = s_eval && (s_hit || s_last);
  assign lo_idx    = (s_hit && (jd_r != '0)) ? jd_r - 1'b1 : jd_r;
  assign lo_val    = (s_hit && (jd_r != '0)) ? prev_r : s_bp;

  always_ff @(posedge clk) begin
    if (srch) begin
      j_r  <= rd_idx + 1'b1;
      jd_r <= rd_idx;
    end
    if (s_eval) prev_r <= s_bp;
    if (s_done && srch_x) begin
      ix0_r <= XAW'(lo_idx);
      ix1_r <= XAW'(jd_r);
      xlo_r <= lo_val;
      xhi_r <= s_bp;
    end
    if (s_done && !srch_x) begin
      iy0_r <= YAW'(lo_idx);
      iy1_r <= YAW'(jd_r);
      ylo_r <= lo_val;
      yhi_r <= s_bp;
    end
  end

  // restoring divider for the fraction, one quotient bit a cycle
  logic                 div, div_x, d_deg, d_ge, d_done;
  logic signed [31:0]   d_q, d_lo, d_hi;
  logic signed [DW-1:0] ax_r, dx_r;
  logic [RW-1:0]        rem_r, rem2;
  logic [FRAC_BITS-1:0] quo_r, f_new, fx_r, fy_r;
  logic [CW-1:0]        dcnt_r;
  logic                 dbusy_r;

  assign div_x = (cmd.phase == PH_DIV_X);
  assign div   = div_x || (cmd.phase == PH_DIV_Y);
  assign d_q   = div_x ? qx_r : qy_r;
  assign d_lo  = div_x ? xlo_r : ylo_r;
  assign d_hi  = div_x ? xhi_r : yhi_r;
  assign d_deg = (dx_r <= 0) || (ax_r < 0) || (ax_r >= dx_r);
  assign rem2  = {rem_r[RW-2:0], 1'b0};
  assign d_ge  = rem2 >= RW'(unsigned'(dx_r));
  assign f_new = dbusy_r ? {quo_r[FRAC_BITS-2:0], d_ge} : '0;
  assign d_done = div && !cmd.start &&
                  ((!dbusy_r && d_deg) || (dbusy_r && (32'(dcnt_r) == FRAC_BITS - 1)));

  always_ff @(posedge clk) begin
    if (div) begin
      if (cmd.start) begin
        ax_r    <= DW'(d_q) - DW'(d_lo);
        dx_r    <= DW'(d_hi) - DW'(d_lo);
        dbusy_r <= 1'b0;
      end else if (!dbusy_r) begin
        rem_r   <= RW'(unsigned'(ax_r));
        quo_r   <= '0;
        dcnt_r  <= '0;
        dbusy_r <= !d_deg;
      end else begin
        rem_r  <= d_ge ? rem2 - RW'(unsigned'(dx_r)) : rem2;
        quo_r  <= {quo_r[FRAC_BITS-2:0], d_ge};
        dcnt_r <= dcnt_r + 1'b1;
      end
    end
    if (d_done && div_x) fx_r <= f_new;
    if (d_done && !div_x) fy_r <= f_new;
  end

  // corner fetch: g00, g10, g01, g11
  logic               grid, g_done;
  logic [1:0]         gj_r, gjd_r, g_rd;
  logic signed [31:0] g_r [4];

  assign grid      = (cmd.phase == PH_GRID);
  assign g_rd      = cmd.start ? 2'd0 : gj_r;
  assign g_rd_addr = GAW'(g_rd[0] ? ix1_r : ix0_r) * GAW'(MAX_Y_POINTS) +
                     GAW'(g_rd[1] ? iy1_r : iy0_r);
  assign g_done    = grid && !cmd.start && (gjd_r == 2'd3);

  always_ff @(posedge clk) begin
    if (grid) begin
      gj_r  <= g_rd + 2'd1;
      gjd_r <= g_rd;
      if (!cmd.start) g_r[gjd_r] <= grid_q_r;
    end
  end

  // three blends: multiply then round and add
  logic                 blend, b_run, b_done;
  logic [2:0]           bcnt_r;
  logic signed [BW-1:0] bl_a, bl_b, r0_r, r1_r, res_r;
  logic [FRAC_BITS-1:0] bl_f;
  logic signed [BW:0]   bl_diff;
  logic signed [PW-1:0] prod_r, bl_t, bl_acc;

  assign blend  = (cmd.phase == PH_BLEND);
  assign b_run  = blend && !cmd.start;
  assign b_done = b_run && (bcnt_r == 3'd5);

  always_comb begin
    case (bcnt_r[2:1])
      2'd0: begin
        bl_a = BW'(g_r[0]);
        bl_b = BW'(g_r[1]);
        bl_f = fx_r;
      end
      2'd1: begin
        bl_a = BW'(g_r[2]);
        bl_b = BW'(g_r[3]);
        bl_f = fx_r;
      end
      default: begin
        bl_a = r0_r;
        bl_b = r1_r;
        bl_f = fy_r;
      end
    endcase
  end

  assign bl_diff = (BW + 1)'(bl_b) - (BW + 1)'(bl_a);
  assign bl_t    = prod_r + RND;
  assign bl_acc  = (bl_t >>> FRAC_BITS) + PW'(bl_a);

  always_ff @(posedge clk) begin
    if (blend) begin
      if (cmd.start) begin
        bcnt_r <= '0;
      end else begin
        bcnt_r <= bcnt_r + 3'd1;
        if (!bcnt_r[0]) begin
          prod_r <= PW'(bl_diff) * PW'($signed({1'b0, bl_f}));
        end else begin
          case (bcnt_r[2:1])
            2'd0:    r0_r  <= BW'(bl_acc);
            2'd1:    r1_r  <= BW'(bl_acc);
            default: res_r <= BW'(bl_acc);
          endcase
        end
      end
    end
  end

  // saturation and output register
  logic               sat_hi, sat_lo;
  logic signed [31:0] res_sat;
  logic signed [31:0] out_result_r;
  logic               out_status_r;

  assign sat_hi  = !res_r[BW-1] && (|res_r[BW-2:31]);
  assign sat_lo  = res_r[BW-1] && !(&res_r[BW-2:31]);
  assign res_sat = sat_hi ? 32'sh7fffffff : (sat_lo ? 32'sh80000000 : res_r[31:0]);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_result_r <= sts.empty ? BAD_RESULT : res_sat;
      out_status_r <= sts.empty;
    end
  end

  assign out_result = out_result_r;
  assign out_status = out_status_r;
  assign sts.done   = s_done || d_done || g_done || b_done;

endmodule

[design/bilinear_table_lookup_2d_unit.sv]
// Two-dimensional bilinear lookup table with edge clamping. Software fills the
// x and y breakpoints (ascending, distinct) and the value grid through write
// transfers on the input channel, sets the counts in use through the APB
// registers (x_count at 0x0, y_count at 0x4), then sends evaluate transfers.
// A write transfer produces no result. An evaluate with an empty axis returns
// status 1 and -999.999. A normal evaluate runs the x and y breakpoint searches
// (one breakpoint a cycle), the bit-serial divider that forms the 24-bit
// fraction of each axis (its bit-serial steps skipped on a collapsed axis), the
// corner fetch and the blends. One item is in flight at a time; a finished
// result sits in an output register so the next transfer can be taken while it
// waits. A result that is still waiting when the next one is ready holds the
// unit in its last step, so output stalls delay the unit.
`include "bilinear_table_lookup_2d_unit_defines.svh"
module bilinear_table_lookup_2d_unit import btl2d_pkg::*; #(
  parameter int MAX_X_POINTS = DEF_MAX_X_POINTS,
  parameter int MAX_Y_POINTS = DEF_MAX_Y_POINTS
) (
  input  logic        clk,
  input  logic        rst_n,
  btl2d_in_if.sink    in_ch,
  btl2d_out_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  // configuration registers, decoded on the word address bit only
  logic [COUNT_W-1:0] x_count_r, y_count_r;
  logic               cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_count_r <= '0;
      y_count_r <= '0;
    end else if (cfg_wr) begin
      if (paddr[2]) y_count_r <= pwdata[COUNT_W-1:0];
      else          x_count_r <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = paddr[2] ? {{(32 - COUNT_W){1'b0}}, y_count_r}
                           : {{(32 - COUNT_W){1'b0}}, x_count_r};

  // controller and datapath
  cmd_t cmd;
  sts_t sts;

  btl2d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_action (in_ch.action),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  btl2d_dp #(
    .MAX_X_POINTS (MAX_X_POINTS),
    .MAX_Y_POINTS (MAX_Y_POINTS)
  ) u_dp (
    .clk         (clk),
    .cmd         (cmd),
    .sts         (sts),
    .action      (in_ch.action),
    .index_x     (in_ch.index_x),
    .index_y     (in_ch.index_y),
    .write_value (in_ch.write_value),
    .query_x     (in_ch.query_x),
    .query_y     (in_ch.query_y),
    .x_count     (x_count_r),
    .y_count     (y_count_r),
    .out_result  (out_ch.result),
    .out_status  (out_ch.status)
  );

  // checks
  `BTL2D_ASSERT_NOW(a_empty_marker, out_ch.valid && out_ch.status, out_ch.result == BAD_RESULT, "empty-table result without marker")
  `BTL2D_ASSERT_NOW(a_valid_counts, out_ch.valid && !out_ch.status, (x_count_r != '0) && (y_count_r != '0), "valid status with an empty axis")
  `BTL2D_ASSERT_NEXT(a_busy_after_eval, in_ch.valid && in_ch.ready && (in_ch.action == ACT_EVAL), !in_ch.ready, "ready held after evaluate transfer")

endmodule

[tb/sv/tb_bilinear_table_lookup_2d_unit.sv]
// testbench for the bilinear table lookup unit: directed and random transfers against a predictor
`timescale 1ns / 100ps
module tb_bilinear_table_lookup_2d_unit;
  import btl2d_pkg::*;

  localparam int NPTS     = 16;
  localparam int REG_XCNT = 0;
  localparam int REG_YCNT = 1;
  localparam int SETTLE   = 120;

  typedef struct packed {
    logic signed [31:0] value;
    logic               empty;
  } lookup_t;

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  btl2d_in_if  in_ch ();
  btl2d_out_if out_ch ();

  bilinear_table_lookup_2d_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // predictor state: the table contents and counts as the unit should hold them
  logic signed [31:0] xs_tbl [NPTS];
  logic signed [31:0] ys_tbl [NPTS];
  logic signed [31:0] grid_tbl [NPTS][NPTS];
  logic [4:0] xs_used, ys_used;
  lookup_t expected_q [$];
  int errors;
  int tx_done;

  always begin
    clk = 1'b1; #1;
    clk = 1'b0; #1;
  end

  // generous fixed limit: ~1500 items, with stalls
  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  // gap length: mostly short, sometimes long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // first breakpoint strictly above q, collapsed at both ends
  function automatic void find_span(input logic signed [31:0] q,
                                    input logic signed [31:0] bp [NPTS],
                                    input int n, output int lo, output int hi);
    lo = n - 1;
    hi = n - 1;
    for (int j = 0; j < n; j++) begin
      if (q < bp[j]) begin
        hi = j;
        lo = (j == 0) ? 0 : j - 1;
        return;
      end
    end
  endfunction

  function automatic longint span_frac(longint q, longint lo, longint hi);
    longint ax, dx;
    if (hi <= lo || q < lo) return 0;
    ax = q - lo;
    dx = hi - lo;
    if (ax >= dx) return 0;
    return (ax <<< FRAC_BITS) / dx;
  endfunction

  // a + (b - a) * f rounded half up, floor division on the product with the Q0.24 fraction
  function automatic longint mix(longint a, longint b, longint f);
    longint t;
    t = (b - a) * f + (longint'(1) <<< (FRAC_BITS - 1));
    return a + (t >>> FRAC_BITS);
  endfunction

  function automatic lookup_t predict_lookup(logic signed [31:0] qx, logic signed [31:0] qy);
    lookup_t r;
    int nx, ny, x0, x1, y0, y1;
    longint fx, fy, r0, r1, v;
    nx = (xs_used > NPTS) ? NPTS : xs_used;
    ny = (ys_used > NPTS) ? NPTS : ys_used;
    if (nx == 0 || ny == 0) begin
      r.value = BAD_RESULT;
      r.empty = 1'b1;
      return r;
    end
    find_span(qx, xs_tbl, nx, x0, x1);
    find_span(qy, ys_tbl, ny, y0, y1);
    fx = span_frac(qx, xs_tbl[x0], xs_tbl[x1]);
    fy = span_frac(qy, ys_tbl[y0], ys_tbl[y1]);
    r0 = mix(grid_tbl[x0][y0], grid_tbl[x1][y0], fx);
    r1 = mix(grid_tbl[x0][y1], grid_tbl[x1][y1], fx);
    v = mix(r0, r1, fy);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    r.value = v[31:0];
    r.empty = 1'b0;
    return r;
  endfunction

  // one transfer on the input channel; the predictor is updated at acceptance
  // valid stays up afterwards so a following call can go back to back;
  // a gap or wait_drained drops it
  task automatic send_item(input logic [1:0] act, input logic [3:0] ix, input logic [3:0] iy,
                           input logic signed [31:0] wv, input logic signed [31:0] qx,
                           input logic signed [31:0] qy, input bit no_gap = 0);
    int g;
    g = no_gap ? 0 : gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.action      <= act;
    in_ch.index_x     <= ix;
    in_ch.index_y     <= iy;
    in_ch.write_value <= wv;
    in_ch.query_x     <= qx;
    in_ch.query_y     <= qy;
    do @(posedge clk); while (!in_ch.ready);
    case (act)
      ACT_WR_X:    xs_tbl[ix] = wv;
      ACT_WR_Y:    ys_tbl[iy] = wv;
      ACT_WR_GRID: grid_tbl[ix][iy] = wv;
      default:     expected_q = {expected_q, predict_lookup(qx, qy)};
    endcase
    tx_done++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // apb write, setup then access; only while the unit is idle
  task automatic reg_write(input int idx, input logic [31:0] val);
    paddr <= 3'(idx * 4); pwdata <= val; pwrite <= 1'b1; psel <= 1'b1; penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == REG_XCNT) xs_used = val[4:0];
    else ys_used = val[4:0];
  endtask

  task automatic set_counts(input logic [31:0] nx, input logic [31:0] ny);
    wait_drained();
    reg_write(REG_XCNT, nx);
    reg_write(REG_YCNT, ny);
  endtask

  // ascending distinct breakpoints, random spacing; every grid entry written
  task automatic load_table(input int span);
    logic signed [31:0] base;
    longint p;
    base = $urandom_range(0, 1) ? -$signed(32'($urandom_range(0, span))) :
                                  $signed(32'($urandom_range(0, span)));
    p = base;
    for (int i = 0; i < NPTS; i++) begin
      send_item(ACT_WR_X, 4'(i), 4'($urandom), p[31:0], $urandom, $urandom);
      p += $urandom_range(1, span / 8 + 1);
    end
    p = base;
    for (int i = 0; i < NPTS; i++) begin
      send_item(ACT_WR_Y, 4'($urandom), 4'(i), p[31:0], $urandom, $urandom);
      p += $urandom_range(1, span / 8 + 1);
    end
    for (int i = 0; i < NPTS; i++)
      for (int j = 0; j < NPTS; j++)
        send_item(ACT_WR_GRID, 4'(i), 4'(j), $urandom, $urandom, $urandom);
  endtask

  task automatic eval_point(input logic signed [31:0] qx, input logic signed [31:0] qy);
    send_item(ACT_EVAL, 4'($urandom), 4'($urandom), $urandom, qx, qy);
  endtask

  // result side: random stalls, each transfer compared with the oldest expectation
  initial begin
    lookup_t want;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(10, 60)) @(negedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 9) < 7) ? 1'b1 : ($urandom_range(0, 29) != 0);
      end
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (out_ch.result !== want.value) begin
            $error("result: expected %0d, got %0d", want.value, out_ch.result);
            errors++;
          end
          if (out_ch.status !== want.empty) begin
            $error("status: expected %0b, got %0b", want.empty, out_ch.status);
            errors++;
          end
        end
      end
    end
  end

  // empty axes right after reset, then one axis empty
  task automatic test_empty_axes();
    eval_point(32'sh7fffffff, 32'sh80000000);
    load_table(1 << 20);
    set_counts(5, 0);
    eval_point(0, 0);
    set_counts(0, 16);
    eval_point(32'sh80000000, 32'sh7fffffff);
  endtask

  // field extremes, clamping, breakpoint hits, oversize counts, ignored indexes
  task automatic test_directed();
    set_counts(16, 16);
    eval_point(32'sh80000000, 32'sh80000000);
    eval_point(32'sh7fffffff, 32'sh7fffffff);
    eval_point(xs_tbl[3], ys_tbl[7]);
    eval_point(xs_tbl[15], ys_tbl[0]);
    eval_point(xs_tbl[4] + 1, ys_tbl[9] - 1);
    // saturating grid corners
    send_item(ACT_WR_GRID, 4'd0, 4'd0, 32'sh80000000, 0, 0);
    send_item(ACT_WR_GRID, 4'd1, 4'd0, 32'sh7fffffff, 0, 0);
    send_item(ACT_WR_GRID, 4'd0, 4'd1, 32'sh7fffffff, 0, 0);
    send_item(ACT_WR_GRID, 4'd1, 4'd1, 32'sh80000000, 0, 0);
    eval_point(xs_tbl[0] + (xs_tbl[1] - xs_tbl[0]) / 2, ys_tbl[0] + 1);
    set_counts(31, 17);
    eval_point(xs_tbl[14] + 1, ys_tbl[1]);
    set_counts(1, 1);
    eval_point(xs_tbl[0] - 1, ys_tbl[0] + 1);
    set_counts(2, 16);
    // breakpoints out of order: search still sound
    send_item(ACT_WR_Y, 4'd0, 4'd5, ys_tbl[2] - 7, 0, 0);
    eval_point(xs_tbl[1] - 1, ys_tbl[5]);
    eval_point($urandom, $urandom);
  endtask

  // random evaluations and grid writes over several table loads and count settings
  task automatic test_random(input int n_items);
    int sent, nx, ny;
    sent = 0;
    while (sent < n_items) begin
      if (sent % 600 == 0) begin
        wait_drained();
        load_table($urandom_range(0, 1) ? (1 << 12) : (1 << 28));
        sent += 288;
      end
      if (sent % 100 < 2) begin
        nx = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16);
        ny = $urandom_range(0, 3) == 0 ? $urandom_range(0, 31) : $urandom_range(1, 16);
        set_counts(nx, ny);
      end
      case ($urandom_range(0, 9))
        0: eval_point($urandom, $urandom);
        1: send_item(ACT_WR_GRID, 4'($urandom), 4'($urandom), $urandom, $urandom, $urandom);
        2: eval_point(xs_tbl[$urandom_range(0, 15)], ys_tbl[$urandom_range(0, 15)]);
        default:
          eval_point(xs_tbl[0] + $signed(32'($urandom_range(0, xs_tbl[15] - xs_tbl[0] + 64))) - 32,
                     ys_tbl[0] + $signed(32'($urandom_range(0, ys_tbl[15] - ys_tbl[0] + 64))) - 32);
      endcase
      sent++;
    end
  endtask

  initial begin
    errors = 0;
    tx_done = 0;
    xs_used = 0;
    ys_used = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.action = ACT_WR_X; in_ch.index_x = '0; in_ch.index_y = '0;
    in_ch.write_value = '0; in_ch.query_x = '0; in_ch.query_y = '0;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_empty_axes();
    test_directed();
    test_random(1400);
    wait_drained();
    if (errors == 0 && expected_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
